@@ design/windowed_level_statistics_history_top_defines.svh @@
// Assertion macros for the level statistics history block.
`ifndef WINDOWED_LEVEL_STATISTICS_HISTORY_TOP_DEFINES_SVH
`define WINDOWED_LEVEL_STATISTICS_HISTORY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define WLSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define WLSH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/wlsh_pkg.sv @@
// Shared types and constants of the level statistics history block.
package wlsh_pkg;

  localparam int RING_DEPTH   = 128;               // power of two
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int CNT_W        = RING_AW + 1;
  localparam int SAVE_EVERY   = 4;
  localparam int CLOSE_W      = 8;
  localparam int LEVEL_OFFSET = 1200;
  localparam int LEVEL_MAX    = 1200;
  localparam int LVL_W        = 11;
  localparam int SUM_W        = 27;
  localparam int CNT16_W      = 16;
  localparam int SEQ_W        = 32;

  localparam logic [1:0] CMD_ADD       = 2'd0;
  localparam logic [1:0] CMD_READ      = 2'd1;
  localparam logic [1:0] CMD_CLR_BKT   = 2'd2;
  localparam logic [1:0] CMD_CLR_SEQ   = 2'd3;

  localparam logic [1:0] CLS_GREEN  = 2'd1;
  localparam logic [1:0] CLS_ORANGE = 2'd2;
  localparam logic [1:0] CLS_RED    = 2'd3;

  // Closed bucket record, sequence number in the lowest bits.
  typedef struct packed {
    logic [CNT16_W-1:0] red;
    logic [CNT16_W-1:0] orange;
    logic [CNT16_W-1:0] green;
    logic [LVL_W-1:0]   peak;
    logic [LVL_W-1:0]   mean;
    logic [CNT16_W-1:0] dur;
    logic [SEQ_W-1:0]   seq;
  } rec_t;

endpackage

@@ design/wlsh_div.sv @@
// Restoring divider, one quotient bit per cycle, for the bucket mean.
module wlsh_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wlsh_pkg::SUM_W-1:0]     dividend,
  input  logic [wlsh_pkg::CNT16_W-1:0]   divisor,
  output logic                           done,
  output logic [wlsh_pkg::LVL_W-1:0]     quotient
);
  import wlsh_pkg::*;

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [ITER_W-1:0]    iter_r;
  logic [CNT16_W-1:0]   rem_r;
  logic [SUM_W-1:0]     quo_r;
  logic [CNT16_W-1:0]   dvs_r;
  logic [CNT16_W:0]     rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? CNT16_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT16_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[LVL_W-1:0];

endmodule

@@ design/windowed_level_statistics_history_top.sv @@
// Per-second level statistics, bucket close with mean, and a ring of closed buckets.
// Flow from request accept to result: add without close, clear or read miss go straight
// to the output stage, a read hit reads the ring first, and an add that closes a bucket
// waits for the 27-step serial divider. One request is in work at a time; a result
// waiting behind a full output register stalls the following request.
// Reset (sync, rst_n low) clears counters, sequence 1, length 300; ring not cleared.
module windowed_level_statistics_history_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,      // bucket_seconds
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,      // alarm_class[1:0], level_dbfs_x10[17:2],
                                      // level_valid[18], record_index[25:19], zero
  input  logic [1:0]   in_tuser,      // command[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,     // sequence_res[31:0], duration_seconds[47:32],
                                      // mean_level[58:48], peak_level[69:59],
                                      // green_seconds[85:70], orange_seconds[101:86],
                                      // red_seconds[117:102], stored_count[125:118],
                                      // persist_due[126], sequence_save_due[127]
  output logic [0:0]   out_tuser      // bucket_present[0]
);
  import wlsh_pkg::*;

  `include "windowed_level_statistics_history_top_defines.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state_r;
  logic [15:0]         bkt_sec_r;
  logic [SUM_W-1:0]    sum_r;
  logic [LVL_W-1:0]    peak_r;
  logic [CNT16_W-1:0]  vcnt_r;
  logic [CNT16_W-1:0]  green_r;
  logic [CNT16_W-1:0]  orange_r;
  logic [CNT16_W-1:0]  red_r;
  logic [CNT16_W-1:0]  elapsed_r;
  logic [SEQ_W-1:0]    next_seq_r;
  logic [RING_AW-1:0]  oldest_r;
  logic [CNT_W-1:0]    entry_cnt_r;
  logic [CLOSE_W-1:0]  closed_r;
  logic                seq_dirty_r;
  logic [RING_AW-1:0]  wr_addr_r;
  logic                zero_mean_r;
  rec_t                res_r;
  logic                res_hit_r;
  rec_t                mem_q_r;
  logic                out_tvalid_r;
  logic [127:0]        out_tdata_r;
  logic                out_tuser_r;

  rec_t                ring_mem [RING_DEPTH];

  logic                in_acc;
  logic [1:0]          cmd;
  logic [1:0]          cls;
  logic signed [15:0]  lvl_raw;
  logic                lvl_ok;
  logic [RING_AW-1:0]  ridx;
  logic signed [16:0]  lvl_off;
  logic [LVL_W-1:0]    lvl_clamp;
  logic [SUM_W-1:0]    sum_new;
  logic [LVL_W-1:0]    peak_new;
  logic [CNT16_W-1:0]  vcnt_new;
  logic [CNT16_W-1:0]  green_new;
  logic [CNT16_W-1:0]  orange_new;
  logic [CNT16_W-1:0]  red_new;
  logic [CNT16_W-1:0]  elapsed_inc;
  logic                close;
  logic                rd_hit;
  logic                mem_re;
  logic [RING_AW-1:0]  mem_raddr;
  logic                mem_we;
  rec_t                mem_wdata;
  logic [SEQ_W-1:0]    seq_inc;
  logic                div_start;
  logic                div_done;
  logic [LVL_W-1:0]    div_quo;
  logic                out_free;
  rec_t                out_rec;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  assign cmd     = in_tuser;
  assign cls     = in_tdata[1:0];
  assign lvl_raw = in_tdata[17:2];
  assign lvl_ok  = in_tdata[18];
  assign ridx    = in_tdata[25:19];

  // Offset and clamp the level.
  assign lvl_off = 17'($signed({lvl_raw[15], lvl_raw}) + 17'sd1200);
  always_comb begin
    if (lvl_off[16]) begin
      lvl_clamp = '0;
    end else if (lvl_off > 17'(LEVEL_MAX)) begin
      lvl_clamp = LVL_W'(LEVEL_MAX);
    end else begin
      lvl_clamp = lvl_off[LVL_W-1:0];
    end
  end

  assign sum_new    = lvl_ok ? (sum_r + {{(SUM_W-LVL_W){1'b0}}, lvl_clamp}) : sum_r;
  assign peak_new   = (lvl_ok && (lvl_clamp > peak_r)) ? lvl_clamp : peak_r;
  assign vcnt_new   = lvl_ok ? (vcnt_r + 16'd1) : vcnt_r;
  assign green_new  = (cls == CLS_GREEN)  ? (green_r + 16'd1)  : green_r;
  assign orange_new = (cls == CLS_ORANGE) ? (orange_r + 16'd1) : orange_r;
  assign red_new    = (cls == CLS_RED)    ? (red_r + 16'd1)    : red_r;
  assign elapsed_inc = elapsed_r + 16'd1;
  assign close      = (elapsed_inc >= bkt_sec_r);
  assign seq_inc    = next_seq_r + 32'd1;

  assign rd_hit    = ({1'b0, ridx} < entry_cnt_r);
  assign mem_re    = in_acc && (cmd == CMD_READ) && rd_hit;
  assign mem_raddr = oldest_r + ridx;
  assign div_start = in_acc && (cmd == CMD_ADD) && close;

  always_comb begin
    mem_wdata      = res_r;
    mem_wdata.mean = zero_mean_r ? '0 : div_quo;
  end
  assign mem_we = (state_r == ST_DIV) && div_done;

  assign out_free = !out_tvalid_r || out_tready;

  wlsh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (vcnt_new),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_addr_r] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= ring_mem[mem_raddr];
    end
  end

  // Control and running statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bkt_sec_r    <= 16'd300;
      sum_r        <= '0;
      peak_r       <= '0;
      vcnt_r       <= '0;
      green_r      <= '0;
      orange_r     <= '0;
      red_r        <= '0;
      elapsed_r    <= '0;
      next_seq_r   <= 32'd1;
      oldest_r     <= '0;
      entry_cnt_r  <= '0;
      closed_r     <= '0;
      seq_dirty_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bkt_sec_r <= cfg_data;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (cmd)
              CMD_ADD: begin
                if (close) begin
                  sum_r     <= '0;
                  peak_r    <= '0;
                  vcnt_r    <= '0;
                  green_r   <= '0;
                  orange_r  <= '0;
                  red_r     <= '0;
                  elapsed_r <= '0;
                  next_seq_r <= (seq_inc == '0) ? 32'd1 : seq_inc;
                  if (entry_cnt_r == CNT_W'(RING_DEPTH)) begin
                    oldest_r <= oldest_r + RING_AW'(1);
                  end else begin
                    entry_cnt_r <= entry_cnt_r + CNT_W'(1);
                  end
                  if (closed_r != {CLOSE_W{1'b1}}) begin
                    closed_r <= closed_r + CLOSE_W'(1);
                  end
                  seq_dirty_r <= 1'b1;
                  state_r     <= ST_DIV;
                end else begin
                  sum_r     <= sum_new;
                  peak_r    <= peak_new;
                  vcnt_r    <= vcnt_new;
                  green_r   <= green_new;
                  orange_r  <= orange_new;
                  red_r     <= red_new;
                  elapsed_r <= elapsed_inc;
                  state_r   <= ST_DONE;
                end
              end
              CMD_READ: begin
                state_r <= rd_hit ? ST_RD : ST_DONE;
              end
              CMD_CLR_BKT: begin
                closed_r <= '0;
                state_r  <= ST_DONE;
              end
              CMD_CLR_SEQ: begin
                seq_dirty_r <= 1'b0;
                state_r     <= ST_DONE;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_DONE;
          end
        end
        ST_RD: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result staging and output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_hit_r <= (cmd == CMD_ADD) ? close : ((cmd == CMD_READ) && rd_hit);
      if (cmd == CMD_ADD) begin
        res_r.seq    <= next_seq_r;
        res_r.dur    <= elapsed_inc;
        res_r.mean   <= '0;
        res_r.peak   <= peak_new;
        res_r.green  <= green_new;
        res_r.orange <= orange_new;
        res_r.red    <= red_new;
        zero_mean_r  <= (vcnt_new == '0);
        wr_addr_r    <= oldest_r + entry_cnt_r[RING_AW-1:0];
      end
    end
    if (mem_we) begin
      res_r <= mem_wdata;
    end
    if (state_r == ST_RD) begin
      res_r <= mem_q_r;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_tuser_r <= res_hit_r;
      out_tdata_r <= {seq_dirty_r, (closed_r >= CLOSE_W'(SAVE_EVERY)), entry_cnt_r, out_rec};
    end
  end

  assign out_rec    = res_hit_r ? res_r : '0;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `WLSH_ASSERT_IMP(a_oldest_zero_until_full, entry_cnt_r != CNT_W'(RING_DEPTH), oldest_r == '0, "oldest slot moved before the ring filled")
  `WLSH_ASSERT_IMP(a_div_done_in_div, div_done, state_r == ST_DIV, "divider finished outside the close sequence")
  `WLSH_ASSERT_NXT(a_seq_never_zero, 1'b1, next_seq_r != '0, "sequence number reached zero")

endmodule
